@@ src/kli_pkg.sv @@
// Shared types, constants and helpers for the keyframe linear interpolator.
// No dependencies; every other file depends on this package.
package kli_pkg;

   localparam int MAX_KEYS_DEFAULT = 256;
   localparam int DATA_W           = 32;
   localparam int SCALE_W          = 24;
   localparam int FRAC_W           = 16;
   localparam int STORED_W         = 9;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 32;
   localparam int DIV_STEPS        = 16;
   localparam int DIV_CNT_W        = $clog2(DIV_STEPS + 1);

   localparam logic [SCALE_W-1:0] UNIT_SCALE_RESET = 24'h010000;
   localparam logic [SCALE_W-1:0] UNIT_SCALE_INV_RESET = 24'h010000;
   localparam logic signed [DATA_W-1:0] DEFAULT_VALUE_RESET = 32'sd0;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNIT_SCALE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNIT_SCALE_INV = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_VALUE  = 2'd2;

   typedef enum logic [1:0] {
      MODE_APPEND_RAW    = 2'd0,
      MODE_APPEND_SCALED = 2'd1,
      MODE_EVALUATE      = 2'd2,
      MODE_CLEAR         = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RD_FIRST = 2'd0,
      RD_LAST  = 2'd1,
      RD_SCAN  = 2'd2
   } rd_sel_type;

   typedef enum logic [1:0] {
      XS_KEY_VALUE = 2'd0,
      XS_DEFAULT   = 2'd1,
      XS_READ      = 2'd2,
      XS_INTERP    = 2'd3
   } x_src_type;

   typedef struct packed {
      logic       load_item;
      logic       rd_issue;
      rd_sel_type rd_sel;
      logic       prev_load;
      logic       scan_init;
      logic       scan_next;
      logic       div_start;
      logic       div_step;
      logic       interp_mul;
      logic       x_load;
      x_src_type  x_src;
      logic       scale_mul;
      logic       scale_sat;
      logic       mem_write;
      logic       count_clear;
      logic       rsp_load;
      status_type rsp_status;
   } kli_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     full;
      logic     empty;
      logic     q_le;
      logic     q_ge;
      logic     q_eq;
      logic     idx_last;
      logic     div_done;
      logic     rsp_free;
   } kli_sts_type;

   // Clamp a wide signed value to the signed 32-bit range.
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (x > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (x < lo) begin
         return 32'sh8000_0000;
      end
      return x[DATA_W-1:0];
   endfunction

endpackage

@@ src/kli_channels.sv @@
// Valid/ready channel interfaces for request and response items.
// Depends on kli_pkg for field widths.
interface kli_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          mode;
   logic signed [kli_pkg::DATA_W-1:0]   key_time;
   logic signed [kli_pkg::DATA_W-1:0]   key_value;
   modport source(output valid, mode, key_time, key_value, input ready);
   modport sink(input valid, mode, key_time, key_value, output ready);
endinterface

interface kli_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [kli_pkg::DATA_W-1:0]   result_value;
   logic [1:0]                          status;
   logic [kli_pkg::STORED_W-1:0]        stored_keys;
   modport source(output valid, result_value, status, stored_keys, input ready);
   modport sink(input valid, result_value, status, stored_keys, output ready);
endinterface

@@ src/kli_ctrl.sv @@
// Sequencer for append, clear and evaluate items.
// Depends on kli_pkg; drives kli_datapath through command and status structs.
module kli_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kli_pkg::kli_sts_type sts,
   output kli_pkg::kli_cmd_type cmd
);
   import kli_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_CHK_FIRST, S_CHK_LAST, S_SCAN_RD, S_SCAN_CHK,
      S_DIV, S_IMUL, S_IADD, S_SMUL, S_SSAT, S_WRITE, S_FINISH
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      cmd            = '0;
      cmd.rsp_status = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = ST_OK;
            case (sts.mode)
               MODE_APPEND_RAW: begin
                  if (sts.full) begin
                     status_in = ST_FULL;
                     state_in  = S_FINISH;
                  end else begin
                     state_in = S_WRITE;
                  end
               end
               MODE_APPEND_SCALED: begin
                  if (sts.full) begin
                     status_in = ST_FULL;
                     state_in  = S_FINISH;
                  end else begin
                     cmd.x_load = 1'b1;
                     cmd.x_src  = XS_KEY_VALUE;
                     state_in   = S_SMUL;
                  end
               end
               MODE_EVALUATE: begin
                  if (sts.empty) begin
                     status_in  = ST_EMPTY;
                     cmd.x_load = 1'b1;
                     cmd.x_src  = XS_DEFAULT;
                     state_in   = S_SMUL;
                  end else begin
                     cmd.rd_issue = 1'b1;
                     cmd.rd_sel   = RD_FIRST;
                     state_in     = S_CHK_FIRST;
                  end
               end
               default: begin
                  cmd.count_clear = 1'b1;
                  state_in        = S_FINISH;
               end
            endcase
         end
         S_CHK_FIRST: begin
            cmd.prev_load = 1'b1;
            if (sts.q_le) begin
               cmd.x_load = 1'b1;
               cmd.x_src  = XS_READ;
               state_in   = S_SMUL;
            end else begin
               cmd.rd_issue = 1'b1;
               cmd.rd_sel   = RD_LAST;
               state_in     = S_CHK_LAST;
            end
         end
         S_CHK_LAST: begin
            if (sts.q_ge) begin
               cmd.x_load = 1'b1;
               cmd.x_src  = XS_READ;
               state_in   = S_SMUL;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_sel   = RD_SCAN;
            state_in     = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (sts.q_le || sts.idx_last) begin
               if (sts.q_eq) begin
                  cmd.x_load = 1'b1;
                  cmd.x_src  = XS_READ;
                  state_in   = S_SMUL;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_IMUL;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_IMUL: begin
            cmd.interp_mul = 1'b1;
            state_in       = S_IADD;
         end
         S_IADD: begin
            cmd.x_load = 1'b1;
            cmd.x_src  = XS_INTERP;
            state_in   = S_SMUL;
         end
         S_SMUL: begin
            cmd.scale_mul = 1'b1;
            state_in      = S_SSAT;
         end
         S_SSAT: begin
            cmd.scale_sat = 1'b1;
            state_in = (sts.mode == MODE_APPEND_SCALED) ? S_WRITE : S_FINISH;
         end
         S_WRITE: begin
            cmd.mem_write = 1'b1;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ src/kli_datapath.sv @@
// Key memories, configuration registers, search, divider, multipliers and
// the response register. Depends on kli_pkg; commanded by kli_ctrl.
module kli_datapath #(
   parameter int MAX_KEYS = kli_pkg::MAX_KEYS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_enable,
   input  logic [kli_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [kli_pkg::CSR_DATA_W-1:0]           csr_write_data,
   input  logic [1:0]                               req_mode,
   input  logic signed [kli_pkg::DATA_W-1:0]        req_key_time,
   input  logic signed [kli_pkg::DATA_W-1:0]        req_key_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [kli_pkg::DATA_W-1:0]        rsp_result_value,
   output logic [1:0]                               rsp_status,
   output logic [kli_pkg::STORED_W-1:0]             rsp_stored_keys,
   input  kli_pkg::kli_cmd_type                     cmd,
   output kli_pkg::kli_sts_type                     sts
);
   import kli_pkg::*;

   localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CW = $clog2(MAX_KEYS + 1);

   logic signed [DATA_W-1:0] time_mem  [MAX_KEYS];
   logic signed [DATA_W-1:0] value_mem [MAX_KEYS];

   logic [SCALE_W-1:0]       unit_scale_ff, unit_scale_inv_ff;
   logic signed [DATA_W-1:0] default_value_ff;

   mode_type                 mode_ff;
   logic signed [DATA_W-1:0] q_ff, kv_ff;
   logic signed [DATA_W-1:0] rd_t_ff, rd_v_ff, prev_t_ff, prev_v_ff;
   logic [AW-1:0]            idx_ff, rd_addr;
   logic [CW-1:0]            count_ff;
   logic [DATA_W-1:0]        rem_ff, den_ff;
   logic [FRAC_W-1:0]        quo_ff;
   logic [DIV_CNT_W-1:0]     dcnt_ff;
   logic signed [49:0]       iprod_ff;
   logic signed [DATA_W-1:0] x_ff, y_ff;
   logic signed [56:0]       sprod_ff;

   logic [AW-1:0]            last_addr;
   logic signed [DATA_W:0]   t_diff, q_diff, v_diff;
   logic [DATA_W:0]          rem_sh;
   logic                     rem_ge;
   logic signed [49:0]       iprod_sh;
   logic signed [56:0]       sprod_sh;
   logic signed [DATA_W-1:0] interp_val, x_in;
   logic [SCALE_W-1:0]       factor;
   logic signed [DATA_W-1:0] wr_value;

   assign last_addr = AW'(count_ff - CW'(1));

   always_comb begin
      case (cmd.rd_sel)
         RD_FIRST: rd_addr = '0;
         RD_LAST:  rd_addr = last_addr;
         default:  rd_addr = idx_ff;
      endcase
   end

   assign wr_value = (mode_ff == MODE_APPEND_SCALED) ? y_ff : kv_ff;

   // Key memories: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         time_mem[AW'(count_ff)]  <= q_ff;
         value_mem[AW'(count_ff)] <= wr_value;
      end
      if (cmd.rd_issue) begin
         rd_t_ff <= time_mem[rd_addr];
         rd_v_ff <= value_mem[rd_addr];
      end
   end

   assign t_diff = {rd_t_ff[DATA_W-1], rd_t_ff} - {prev_t_ff[DATA_W-1], prev_t_ff};
   assign q_diff = {q_ff[DATA_W-1], q_ff} - {prev_t_ff[DATA_W-1], prev_t_ff};
   assign v_diff = {rd_v_ff[DATA_W-1], rd_v_ff} - {prev_v_ff[DATA_W-1], prev_v_ff};

   assign rem_sh = {rem_ff, 1'b0};
   assign rem_ge = rem_sh >= {1'b0, den_ff};

   assign iprod_sh   = iprod_ff >>> FRAC_W;
   assign interp_val = sat32(64'(prev_v_ff) + 64'(iprod_sh));
   assign sprod_sh   = sprod_ff >>> FRAC_W;

   assign factor = (mode_ff == MODE_APPEND_SCALED) ? unit_scale_inv_ff : unit_scale_ff;

   always_comb begin
      case (cmd.x_src)
         XS_KEY_VALUE: x_in = kv_ff;
         XS_DEFAULT:   x_in = default_value_ff;
         XS_READ:      x_in = rd_v_ff;
         default:      x_in = interp_val;
      endcase
   end

   // Payload and arithmetic registers.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff <= mode_type'(req_mode);
         q_ff    <= req_key_time;
         kv_ff   <= req_key_value;
      end
      if (cmd.prev_load || cmd.scan_next) begin
         prev_t_ff <= rd_t_ff;
         prev_v_ff <= rd_v_ff;
      end
      if (cmd.scan_init) begin
         idx_ff <= AW'(1);
      end else if (cmd.scan_next) begin
         idx_ff <= idx_ff + AW'(1);
      end
      if (cmd.div_start) begin
         rem_ff  <= q_diff[DATA_W-1:0];
         den_ff  <= t_diff[DATA_W-1:0];
         quo_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_ge ? DATA_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DATA_W-1:0];
         quo_ff  <= {quo_ff[FRAC_W-2:0], rem_ge};
         dcnt_ff <= dcnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.interp_mul) begin
         iprod_ff <= v_diff * $signed({1'b0, quo_ff});
      end
      if (cmd.x_load) begin
         x_ff <= x_in;
      end
      if (cmd.scale_mul) begin
         sprod_ff <= x_ff * $signed({1'b0, factor});
      end
      if (cmd.scale_sat) begin
         y_ff <= sat32(64'(sprod_sh));
      end
      if (cmd.rsp_load) begin
         rsp_result_value <= (mode_ff == MODE_EVALUATE) ? y_ff : '0;
         rsp_status       <= cmd.rsp_status;
         rsp_stored_keys  <= STORED_W'(count_ff);
      end
   end

   // Control state: configuration, key count, response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_scale_ff     <= UNIT_SCALE_RESET;
         unit_scale_inv_ff <= UNIT_SCALE_INV_RESET;
         default_value_ff  <= DEFAULT_VALUE_RESET;
         count_ff          <= '0;
         rsp_valid         <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_UNIT_SCALE:     unit_scale_ff     <= csr_write_data[SCALE_W-1:0];
               CSR_UNIT_SCALE_INV: unit_scale_inv_ff <= csr_write_data[SCALE_W-1:0];
               CSR_DEFAULT_VALUE:  default_value_ff  <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (cmd.count_clear) begin
            count_ff <= '0;
         end else if (cmd.mem_write) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   assign sts.mode     = mode_ff;
   assign sts.full     = (count_ff == CW'(MAX_KEYS));
   assign sts.empty    = (count_ff == '0);
   assign sts.q_le     = (q_ff <= rd_t_ff);
   assign sts.q_ge     = (q_ff >= rd_t_ff);
   assign sts.q_eq     = (q_ff == rd_t_ff);
   assign sts.idx_last = (idx_ff == last_addr);
   assign sts.div_done = (dcnt_ff == DIV_CNT_W'(DIV_STEPS));
   assign sts.rsp_free = !rsp_valid || rsp_ready;

endmodule

@@ src/keyframe_linear_interpolator.sv @@
// Top level of the keyframe linear interpolator: controller plus datapath.
// Depends on kli_pkg, kli_channels, kli_ctrl and kli_datapath.
//
// Holds up to MAX_KEYS (time, value) keyframes in two memories, each with one
// write port and one registered read port, and answers one request item at a
// time with exactly one response item. An evaluate clamps to the first or last
// key when the query lies outside the table; otherwise the linear scan of the
// key memory does one read and one compare per key visited and stops at an
// exact hit or interpolates, using the restoring divider (16 quotient steps and
// a done check) for the Q0.16 weight and the two registered multiplies.
// The next request is taken once the current response has been loaded into
// the output register, even while that response still waits for rsp ready.
// No clearing pass is needed after reset: only keys below the count are read.
module keyframe_linear_interpolator #(
   parameter int MAX_KEYS = kli_pkg::MAX_KEYS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   kli_req_if.sink                         req_channel,
   kli_rsp_if.source                       rsp_channel,
   input  logic                            csr_write_enable,
   input  logic [kli_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kli_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import kli_pkg::*;

   kli_cmd_type cmd;
   kli_sts_type sts;

   // Sequence each item: decode, search, divide, scale, write, respond.
   kli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold keys, configuration and arithmetic; drive the response register.
   kli_datapath #(
      .MAX_KEYS (MAX_KEYS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_mode         (req_channel.mode),
      .req_key_time     (req_channel.key_time),
      .req_key_value    (req_channel.key_value),
      .rsp_valid        (rsp_channel.valid),
      .rsp_ready        (rsp_channel.ready),
      .rsp_result_value (rsp_channel.result_value),
      .rsp_status       (rsp_channel.status),
      .rsp_stored_keys  (rsp_channel.stored_keys),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

@@ src/kli_checker.sv @@
// Port-level assertions for keyframe_linear_interpolator, bound to the top.
// Depends on kli_pkg for status codes and widths.
module kli_checker #(
   parameter int MAX_KEYS = kli_pkg::MAX_KEYS_DEFAULT
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [kli_pkg::DATA_W-1:0]   rsp_result_value,
   input logic [1:0]                          rsp_status,
   input logic [kli_pkg::STORED_W-1:0]        rsp_stored_keys
);
   import kli_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_status) && $stable(rsp_stored_keys))
      else $error("stalled response changed");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> (rsp_stored_keys == '0))
      else $error("empty status with keys held");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |->
         (rsp_result_value == '0) && (rsp_stored_keys == STORED_W'(MAX_KEYS)))
      else $error("dropped append with wrong result or count");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in work");

endmodule

bind keyframe_linear_interpolator kli_checker #(
   .MAX_KEYS (MAX_KEYS)
) u_kli_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_channel.valid),
   .req_ready        (req_channel.ready),
   .rsp_valid        (rsp_channel.valid),
   .rsp_ready        (rsp_channel.ready),
   .rsp_result_value (rsp_channel.result_value),
   .rsp_status       (rsp_channel.status),
   .rsp_stored_keys  (rsp_channel.stored_keys)
);

@@ sim/keyframe_linear_interpolator_tb.sv @@
// Self-checking testbench for the keyframe linear interpolator.
// Depends on kli_pkg, kli_channels and keyframe_linear_interpolator.
// Predicts every response item from a local table model and compares fields.
module keyframe_linear_interpolator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kli_pkg::*;

   localparam int KEY_CAP = 256;

   typedef struct {
      mode_type                 mode;
      logic signed [31:0]       key_time;
      logic signed [31:0]       key_value;
      bit                       typed;       // expectation typed into the row
      logic signed [31:0]       exp_value;
      status_type               exp_status;
      logic [STORED_W-1:0]      exp_stored;
   } stim_row_type;

   typedef struct {
      logic signed [31:0]  value;
      status_type          status;
      logic [STORED_W-1:0] stored;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = CSR_UNIT_SCALE;
   logic [CSR_DATA_W-1:0]   csr_write_data = '0;

   kli_req_if req_channel ();
   kli_rsp_if rsp_channel ();

   keyframe_linear_interpolator DUT (
      .clock(clock),
      .reset(reset),
      .req_channel(req_channel.sink),
      .rsp_channel(rsp_channel.source),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Local copy of the block state.
   logic signed [31:0] key_times [KEY_CAP];
   logic signed [31:0] key_values [KEY_CAP];
   int unsigned        key_count;
   logic [23:0]        out_scale;
   logic [23:0]        in_scale;
   logic signed [31:0] empty_value;

   answer_type pending_answers [$];
   int  mismatch_count = 0;
   bit  sink_stalls = 1'b1;

   function automatic logic signed [31:0] clamp32(input longint x);
      if (x > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end
      if (x < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

   // Arithmetic right shift on longint floors toward minus infinity.
   function automatic logic signed [31:0] apply_scale(input logic signed [31:0] x,
                                                     input logic [23:0] s);
      longint prod;
      prod = longint'(x) * longint'({8'd0, s});
      return clamp32(prod >>> 16);
   endfunction

   function automatic logic signed [31:0] lookup_value(input logic signed [31:0] q);
      int unsigned i;
      longint t1, t2, v1, v2, w;
      if (q <= key_times[0]) begin
         return key_values[0];
      end
      if (q >= key_times[key_count-1]) begin
         return key_values[key_count-1];
      end
      i = 1;
      while (i < key_count - 1 && key_times[i] < q) begin
         i++;
      end
      if (key_times[i] == q) begin
         return key_values[i];
      end
      t1 = key_times[i-1];
      t2 = key_times[i];
      v1 = key_values[i-1];
      v2 = key_values[i];
      w = ((q - t1) <<< 16) / (t2 - t1);
      return clamp32(v1 + (((v2 - v1) * w) >>> 16));
   endfunction

   function automatic answer_type predict_answer(input mode_type m,
                                                 input logic signed [31:0] kt,
                                                 input logic signed [31:0] kv);
      answer_type a;
      a.value = '0;
      a.status = ST_OK;
      case (m)
         MODE_APPEND_RAW, MODE_APPEND_SCALED: begin
            if (key_count >= KEY_CAP) begin
               a.status = ST_FULL;
            end else begin
               key_times[key_count] = kt;
               key_values[key_count] = (m == MODE_APPEND_SCALED) ? apply_scale(kv, in_scale) : kv;
               key_count++;
            end
         end
         MODE_EVALUATE: begin
            if (key_count == 0) begin
               a.value = apply_scale(empty_value, out_scale);
               a.status = ST_EMPTY;
            end else begin
               a.value = apply_scale(lookup_value(kt), out_scale);
            end
         end
         default: key_count = 0;
      endcase
      a.stored = key_count[STORED_W-1:0];
      return a;
   endfunction

   // Write one register while the block is idle; mirror it locally.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_UNIT_SCALE:     out_scale = data[23:0];
         CSR_UNIT_SCALE_INV: in_scale = data[23:0];
         default:            empty_value = data;
      endcase
   endtask

   // Drive one item and hold it until accepted; queue the expected answer.
   task automatic send_item(input mode_type m, input logic signed [31:0] kt,
                            input logic signed [31:0] kv, input bit idle_ok);
      if (idle_ok && $urandom_range(0, 3) == 0) begin
         req_channel.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_channel.valid <= 1'b1;
      req_channel.mode <= m;
      req_channel.key_time <= kt;
      req_channel.key_value <= kv;
      do @(posedge clock); while (!req_channel.ready);
      pending_answers.insert(pending_answers.size(), predict_answer(m, kt, kv));
      @(negedge clock);
   endtask

   task automatic drain_answers();
      req_channel.valid <= 1'b0;
      while (pending_answers.size() != 0) begin
         @(negedge clock);
      end
      // Block may still be finishing internal work; wait out the latency.
      repeat (40) @(negedge clock);
   endtask

   // Response sink: random stall bursts, check every accepted item.
   initial begin
      answer_type e;
      rsp_channel.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (sink_stalls && $urandom_range(0, 3) == 0) begin
            rsp_channel.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_channel.ready <= 1'b1;
         @(posedge clock);
         if (!reset && rsp_channel.valid && rsp_channel.ready) begin
            if (pending_answers.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Unexpected response item: value %0d status %0d keys %0d",
                           rsp_channel.result_value, rsp_channel.status,
                           rsp_channel.stored_keys);
               end
            end else begin
               e = pending_answers.pop_front();
               if (rsp_channel.result_value !== e.value || rsp_channel.status !== e.status ||
                   rsp_channel.stored_keys !== e.stored) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("Mismatch: expected value %0d status %0d keys %0d, got %0d %0d %0d",
                              e.value, e.status, e.stored, rsp_channel.result_value,
                              rsp_channel.status, rsp_channel.stored_keys);
                  end
               end
            end
         end
         @(negedge clock);
      end
   end

   // Hard limit on run time.
   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   stim_row_type directed_rows [$];

   function automatic void add_row(input mode_type m, input logic signed [31:0] kt,
                                   input logic signed [31:0] kv, input bit typed = 0,
                                   input logic signed [31:0] ev = 0,
                                   input status_type es = ST_OK, input int ek = 0);
      stim_row_type r;
      r.mode = m; r.key_time = kt; r.key_value = kv; r.typed = typed;
      r.exp_value = ev; r.exp_status = es; r.exp_stored = ek[STORED_W-1:0];
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   // Build a random, mostly ordered table with clears mixed in, and query it.
   task automatic random_phase(input int items, input bit idle_ok);
      logic signed [31:0] t;
      int unsigned k, sel;
      mode_type m;
      t = $urandom;
      for (k = 0; k < items; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 3) begin
            m = MODE_CLEAR;
         end else if (sel < 40) begin
            m = ($urandom_range(0, 1) == 0) ? MODE_APPEND_RAW : MODE_APPEND_SCALED;
         end else begin
            m = MODE_EVALUATE;
         end
         if (m == MODE_EVALUATE) begin
            send_item(m, (key_count > 1 && $urandom_range(0, 3) != 0) ?
                      key_times[$urandom_range(0, key_count - 2)] + $urandom_range(0, 4096)
                      : $urandom, $urandom, idle_ok);
         end else if (m == MODE_CLEAR) begin
            send_item(m, $urandom, $urandom, idle_ok);
         end else begin
            // Mostly ordered times; occasionally random noise or a repeat.
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
               t = $urandom;
            end else if (sel > 1) begin
               t = t + $urandom_range(1, 8192);
            end
            send_item(m, t, $urandom, idle_ok);
         end
      end
   endtask

   initial begin
      stim_row_type r;
      answer_type got;
      int k;
      req_channel.valid = 1'b0;
      req_channel.mode = MODE_CLEAR;
      req_channel.key_time = '0;
      req_channel.key_value = '0;
      key_count = 0;
      out_scale = UNIT_SCALE_RESET;
      in_scale = UNIT_SCALE_INV_RESET;
      empty_value = DEFAULT_VALUE_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows: empty table, extremes, clamps, exact hits, interpolation.
      add_row(MODE_EVALUATE, 0, 0, 1, 0, ST_EMPTY, 0);
      add_row(MODE_APPEND_RAW, 32'sh8000_0000, 32'sh8000_0000, 1, 0, ST_OK, 1);
      add_row(MODE_APPEND_RAW, 0, 32'sh0001_0000, 1, 0, ST_OK, 2);
      add_row(MODE_APPEND_SCALED, 32'sh0002_0000, 32'sh7FFF_FFFF, 1, 0, ST_OK, 3);
      add_row(MODE_APPEND_RAW, 32'sh0002_0000, -32'sh0004_0000, 1, 0, ST_OK, 4);
      add_row(MODE_APPEND_RAW, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 0, ST_OK, 5);
      add_row(MODE_EVALUATE, 32'sh8000_0000, 0, 1, 32'sh8000_0000, ST_OK, 5);
      add_row(MODE_EVALUATE, 32'sh7FFF_FFFF, -1, 1, 32'sh7FFF_FFFF, ST_OK, 5);
      add_row(MODE_EVALUATE, 0, 0, 1, 32'sh0001_0000, ST_OK, 5);
      add_row(MODE_EVALUATE, 32'sh0000_8000, 0);
      add_row(MODE_EVALUATE, 32'sh0001_FFFF, 0);
      add_row(MODE_EVALUATE, 32'sh0002_0000, 0);
      add_row(MODE_EVALUATE, -32'sh0000_0001, 0);
      add_row(MODE_EVALUATE, 32'sh4000_0000, 0);
      add_row(MODE_APPEND_RAW, -5, 7);
      add_row(MODE_EVALUATE, 32'sh0003_0000, 0);
      add_row(MODE_CLEAR, -1, -1, 1, 0, ST_OK, 0);
      add_row(MODE_EVALUATE, 5, 5, 1, 0, ST_EMPTY, 0);
      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         send_item(r.mode, r.key_time, r.key_value, 1'b1);
         if (r.typed) begin
            got = pending_answers[pending_answers.size() - 1];
            if (got.value !== r.exp_value || got.status !== r.exp_status ||
                got.stored !== r.exp_stored) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Directed row %0d: expected %0d %0d %0d, predicted %0d %0d %0d",
                           i, r.exp_value, r.exp_status, r.exp_stored,
                           got.value, got.status, got.stored);
               end
            end
         end
      end
      drain_answers();

      // Fill the table past full, then hold until every answer is back.
      for (k = 0; k < KEY_CAP + 3; k++) begin
         send_item(MODE_APPEND_RAW, k * 256, $urandom, 1'b0);
      end
      send_item(MODE_EVALUATE, 300, 0, 1'b1);
      send_item(MODE_EVALUATE, 255 * 256 - 1, 0, 1'b1);
      drain_answers();
      send_item(MODE_CLEAR, 0, 0, 1'b1);
      drain_answers();

      // Extreme register settings.
      write_register(CSR_UNIT_SCALE, 32'h00FF_FFFF);
      write_register(CSR_UNIT_SCALE_INV, 32'h0000_0000);
      write_register(CSR_DEFAULT_VALUE, 32'h8000_0000);
      send_item(MODE_EVALUATE, 0, 0, 1'b1);
      random_phase(30, 1'b1);
      drain_answers();
      send_item(MODE_CLEAR, 0, 0, 1'b1);
      drain_answers();
      write_register(CSR_UNIT_SCALE, 32'h0000_0000);
      write_register(CSR_UNIT_SCALE_INV, 32'h00FF_FFFF);
      write_register(CSR_DEFAULT_VALUE, 32'h7FFF_FFFF);
      send_item(MODE_EVALUATE, 0, 0, 1'b1);
      random_phase(30, 1'b1);
      drain_answers();
      write_register(CSR_UNIT_SCALE, $urandom_range(0, 32'h0003_0000));
      write_register(CSR_UNIT_SCALE_INV, $urandom_range(0, 32'h0003_0000));
      write_register(CSR_DEFAULT_VALUE, $urandom);
      random_phase(60, 1'b1);
      drain_answers();
      write_register(CSR_UNIT_SCALE, 32'h0001_0000);
      write_register(CSR_UNIT_SCALE_INV, 32'h0000_8000);
      // Last part of the run without idling on either side.
      sink_stalls = 1'b0;
      random_phase(50, 1'b0);
      drain_answers();

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

@@ sim.f @@
src/kli_pkg.sv
src/kli_channels.sv
src/kli_ctrl.sv
src/kli_datapath.sv
src/keyframe_linear_interpolator.sv
src/kli_checker.sv
sim/keyframe_linear_interpolator_tb.sv
